// ===== design/ycvr_pkg.sv =====
`default_nettype none
package ycvr_pkg;

    // event codes carried in cmd
    localparam logic [2:0] CMD_VEL      = 3'd0;
    localparam logic [2:0] CMD_ODOM     = 3'd1;
    localparam logic [2:0] CMD_PLAN     = 3'd2;
    localparam logic [2:0] CMD_FEEDBACK = 3'd3;
    localparam logic [2:0] CMD_SET_SPIN = 3'd4;
    localparam logic [2:0] CMD_YAW_RST  = 3'd5;
    localparam logic [2:0] CMD_TICK     = 3'd6;
    localparam logic [2:0] CMD_PUBLISH  = 3'd7;

    // configuration register indexes
    localparam logic [1:0] REG_TIMEOUT   = 2'd0;
    localparam logic [1:0] REG_GAIN      = 2'd1;
    localparam logic [1:0] REG_BAND      = 2'd2;
    localparam logic [1:0] REG_INIT_SPIN = 2'd3;

    localparam int CORDIC_STEPS = 16;
    localparam int STEP_BITS    = 4;
    localparam int TURN_BITS    = 16;
    localparam logic [15:0] TMAX = 16'hFFFF;
    localparam logic signed [24:0] CORDIC_K = 25'sd10188014;

    // arctangent table, 32-bit binary angle
    function automatic logic [31:0] atan_lut(input logic [STEP_BITS-1:0] i);
        logic [31:0] r;
        case (i)
            4'd0:  r = 32'd536870912;
            4'd1:  r = 32'd316933406;
            4'd2:  r = 32'd167458907;
            4'd3:  r = 32'd85004756;
            4'd4:  r = 32'd42667331;
            4'd5:  r = 32'd21354465;
            4'd6:  r = 32'd10679838;
            4'd7:  r = 32'd5340245;
            4'd8:  r = 32'd2670163;
            4'd9:  r = 32'd1335087;
            4'd10: r = 32'd667544;
            4'd11: r = 32'd333772;
            4'd12: r = 32'd166886;
            4'd13: r = 32'd83443;
            4'd14: r = 32'd41722;
            default: r = 32'd20861;
        endcase
        return r;
    endfunction

    // controller commands to the datapath
    typedef struct packed {
        logic load;       // capture the accepted item and decode
        logic rot_start;  // begin a rotation of the stored command
        logic rot_step;   // one CORDIC iteration
        logic scale;      // gain multiply of x
        logic scale_y;    // gain multiply of y
        logic hold;       // round, saturate and hold
        logic emit;       // build the result
    } ycvr_ctl_t;

    // datapath status to the controller
    typedef struct packed {
        logic need_rot;   // the item needs a rotation
        logic has_out;    // the item gives a result
        logic last_step;  // CORDIC on its final iteration
    } ycvr_sts_t;

endpackage
`default_nettype wire

// ===== design/ycvr_ctrl.sv =====
`default_nettype none
module ycvr_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_fire,
    input  wire logic               out_fire,
    input  wire ycvr_pkg::ycvr_sts_t sts,
    output ycvr_pkg::ycvr_ctl_t     ctl,
    output logic                    in_ready,
    output logic                    out_valid
);
    import ycvr_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_DECODE = 7'b0000010,
        ST_ROT    = 7'b0000100,
        ST_SCALE  = 7'b0001000,
        ST_SCALEY = 7'b0010000,
        ST_HOLD   = 7'b0100000,
        ST_OUT    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // sequencer
    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        ctl            = '0;
        if (out_fire) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    ctl.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (sts.need_rot) begin
                    ctl.rot_start = 1'b1;
                    state_next    = ST_ROT;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_ROT: begin
                ctl.rot_step = 1'b1;
                if (sts.last_step) begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                ctl.scale  = 1'b1;
                state_next = ST_SCALEY;
            end
            ST_SCALEY: begin
                ctl.scale_y = 1'b1;
                state_next  = ST_HOLD;
            end
            ST_HOLD: begin
                ctl.hold   = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // wait until the output register is free
                if (!out_valid_reg || out_fire) begin
                    ctl.emit   = 1'b1;
                    state_next = ST_IDLE;
                    if (sts.has_out) begin
                        out_valid_next = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    a_load_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.load |-> state_reg == ST_IDLE)
        else $error("load outside idle");
    a_emit_then_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.emit |=> state_reg == ST_IDLE)
        else $error("emit did not return to idle");
    a_rot_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROT && sts.last_step) |=> state_reg == ST_SCALE)
        else $error("rotation did not finish");
endmodule
`default_nettype wire

// ===== design/ycvr_datapath.sv =====
`default_nettype none
module ycvr_datapath #(
    parameter int ANGLE_BITS = 16,
    parameter int VEL_BITS   = 16
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire ycvr_pkg::ycvr_ctl_t          ctl,
    output ycvr_pkg::ycvr_sts_t               sts,
    input  wire logic [2:0]                   in_cmd,
    input  wire logic signed [VEL_BITS-1:0]   in_vx,
    input  wire logic signed [VEL_BITS-1:0]   in_vy,
    input  wire logic signed [15:0]           in_turn,
    input  wire logic [ANGLE_BITS-1:0]        in_angle,
    input  wire logic                         in_synced,
    input  wire logic                         cfg_we,
    input  wire logic [1:0]                   cfg_idx,
    input  wire logic [15:0]                  cfg_data,
    output logic                              o_is_vel,
    output logic signed [VEL_BITS-1:0]        o_vx,
    output logic signed [VEL_BITS-1:0]        o_vy,
    output logic signed [15:0]                o_turn,
    output logic [ANGLE_BITS-1:0]             o_vyaw,
    output logic [ANGLE_BITS-1:0]             o_fyaw,
    output logic                              o_cal
);
    import ycvr_pkg::*;

    localparam int CW = VEL_BITS + 6 + 3;   // CORDIC word with guard and growth
    localparam int PW = CW + 25;            // product width
    localparam int AP = 32 - ANGLE_BITS;

    typedef logic [ANGLE_BITS-1:0] ang_t;

    // configuration
    logic [15:0] timeout_reg, gain_reg, init_spin_reg;
    logic [7:0]  band_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg   <= 16'd250;
            gain_reg      <= 16'd1043;
            band_reg      <= 8'd0;
            init_spin_reg <= 16'd0;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_TIMEOUT:   timeout_reg   <= cfg_data;
                REG_GAIN:      gain_reg      <= cfg_data;
                REG_BAND:      band_reg      <= cfg_data[7:0];
                REG_INIT_SPIN: init_spin_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // state
    ang_t base_reg, fb_reg, comp_reg, vyaw_reg;
    logic f_base_reg, f_fb_reg, f_cal_reg, f_cmd_reg;
    logic signed [VEL_BITS-1:0] cvx_reg, cvy_reg, hvx_reg, hvy_reg;
    logic signed [15:0] cturn_reg, spin_reg, hturn_reg;
    logic ever_reg;
    logic [15:0] su_reg, sa_reg;
    // item latch
    logic need_rot_reg, has_out_reg, is_vel_reg;
    // CORDIC
    logic signed [CW-1:0] x_reg, y_reg;
    logic signed [32:0]   z_reg;
    logic [STEP_BITS-1:0] step_reg;
    logic signed [PW-1:0] px_reg;
    logic signed [PW-1:0] py_reg;
    // result register
    logic                       ro_vel_reg, ro_cal_reg;
    logic signed [VEL_BITS-1:0] ro_vx_reg, ro_vy_reg;
    logic signed [15:0]         ro_turn_reg;
    ang_t                       ro_vyaw_reg, ro_fyaw_reg;

    // helpers
    function automatic logic in_band(input logic signed [VEL_BITS-1:0] v,
                                     input logic [7:0] b);
        logic signed [VEL_BITS:0] m;
        m = v[VEL_BITS-1] ? -{v[VEL_BITS-1], v} : {v[VEL_BITS-1], v};
        return m <= $signed({{(VEL_BITS-7){1'b0}}, b});
    endfunction

    function automatic logic [VEL_BITS-1:0] sat_v(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] s;
        logic signed [PW-1:0] hi, lo;
        s  = (p + (PW'(1) <<< 29)) >>> 30;
        hi = PW'((64'sd1 <<< (VEL_BITS-1)) - 1);
        lo = -hi - PW'(1);
        if (s > hi)      return hi[VEL_BITS-1:0];
        else if (s < lo) return lo[VEL_BITS-1:0];
        return s[VEL_BITS-1:0];
    endfunction

    function automatic logic [15:0] sat16(input logic signed [16:0] v);
        if (v > 17'sd32767)       return 16'h7FFF;
        else if (v < -17'sd32768) return 16'h8000;
        return v[15:0];
    endfunction

    logic        idle;
    logic        tr_band;
    ang_t        cal_base;
    logic [32:0] gprod;
    ang_t        dstep;
    logic [31:0] ang32, theta_ang;
    logic        flip;
    logic [31:0] aflip;
    logic signed [CW-1:0] sx_step, sy_step;
    logic signed [CW-1:0] vx_ext, vy_ext;
    logic signed [31:0] tr_ext;

    assign idle     = sa_reg > timeout_reg;
    assign cal_base = base_reg + comp_reg;
    assign tr_ext   = 32'(in_turn);
    assign tr_band  = (in_turn[15] ? -tr_ext : tr_ext) <= $signed({24'd0, band_reg});
    assign gprod    = 33'($signed({cturn_reg[15], cturn_reg}) * $signed({1'b0, gain_reg})
                          + 33'sd32768);
    assign dstep    = ANGLE_BITS'($signed(gprod) >>> 16);
    assign theta_ang = {vyaw_reg - cal_base, {AP{1'b0}}};
    assign ang32    = theta_ang;
    assign flip     = (ang32 + 32'h4000_0000) >= 32'h8000_0000;
    assign aflip    = flip ? ang32 + 32'h8000_0000 : ang32;
    assign vx_ext   = CW'(cvx_reg) <<< 6;
    assign vy_ext   = CW'(cvy_reg) <<< 6;
    assign sx_step  = x_reg >>> step_reg;
    assign sy_step  = y_reg >>> step_reg;

    assign sts.need_rot  = need_rot_reg;
    assign sts.has_out   = has_out_reg;
    assign sts.last_step = (step_reg == STEP_BITS'(CORDIC_STEPS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0; fb_reg <= '0; comp_reg <= '0; vyaw_reg <= '0;
            f_base_reg <= 1'b0; f_fb_reg <= 1'b0; f_cal_reg <= 1'b0; f_cmd_reg <= 1'b0;
            cvx_reg <= '0; cvy_reg <= '0; cturn_reg <= '0;
            spin_reg <= init_spin_reg;
            hvx_reg <= '0; hvy_reg <= '0; hturn_reg <= '0;
            ever_reg <= 1'b0; su_reg <= TMAX; sa_reg <= TMAX;
            need_rot_reg <= 1'b0; has_out_reg <= 1'b0; is_vel_reg <= 1'b0;
        end else begin
            if (ctl.load) begin
                need_rot_reg <= 1'b0;
                has_out_reg  <= 1'b0;
                is_vel_reg   <= 1'b0;
                case (in_cmd)
                    CMD_VEL: begin
                        cvx_reg <= in_vx; cvy_reg <= in_vy; cturn_reg <= in_turn;
                        f_cmd_reg <= 1'b1;
                        need_rot_reg <= (in_band(in_vx, band_reg) &&
                            in_band(in_vy, band_reg) && tr_band) || idle;
                    end
                    CMD_ODOM: begin
                        if (idle || (in_synced && f_cmd_reg)) begin
                            base_reg   <= in_angle;
                            f_base_reg <= 1'b1;
                            if (!f_cal_reg && f_fb_reg) begin
                                comp_reg  <= fb_reg - in_angle;
                                vyaw_reg  <= fb_reg;
                                f_cal_reg <= 1'b1;
                            end
                        end
                        need_rot_reg <= in_synced && f_cmd_reg;
                    end
                    CMD_PLAN: sa_reg <= '0;
                    CMD_FEEDBACK: begin
                        fb_reg   <= in_angle;
                        f_fb_reg <= 1'b1;
                        if (!f_cal_reg && f_base_reg) begin
                            comp_reg  <= in_angle - base_reg;
                            vyaw_reg  <= in_angle;
                            f_cal_reg <= 1'b1;
                        end
                    end
                    CMD_SET_SPIN: spin_reg <= in_turn;
                    CMD_YAW_RST:  vyaw_reg <= cal_base;
                    CMD_TICK: begin
                        if (su_reg != TMAX) su_reg <= su_reg + 16'd1;
                        if (sa_reg != TMAX) sa_reg <= sa_reg + 16'd1;
                        vyaw_reg    <= vyaw_reg + dstep;
                        has_out_reg <= 1'b1;
                    end
                    default: begin
                        has_out_reg <= 1'b1;
                        is_vel_reg  <= 1'b1;
                        if (ever_reg && su_reg > timeout_reg) begin
                            hvx_reg <= '0;
                            hvy_reg <= '0;
                        end
                    end
                endcase
            end
            if (ctl.hold) begin
                hvx_reg   <= sat_v(px_reg);
                hvy_reg   <= sat_v(py_reg);
                hturn_reg <= sat16(17'(cturn_reg) + 17'(spin_reg));
                ever_reg  <= 1'b1;
                su_reg    <= '0;
            end
        end
    end

    // CORDIC rotation and gain scaling (separate multiplies for x and y)
    always_ff @(posedge aclk) begin
        if (ctl.rot_start) begin
            x_reg    <= flip ? -vx_ext : vx_ext;
            y_reg    <= flip ? -vy_ext : vy_ext;
            z_reg    <= 33'($signed(aflip));
            step_reg <= '0;
        end else if (ctl.rot_step) begin
            if (!z_reg[32]) begin
                x_reg <= x_reg - sy_step;
                y_reg <= y_reg + sx_step;
                z_reg <= z_reg - $signed({1'b0, atan_lut(step_reg)});
            end else begin
                x_reg <= x_reg + sy_step;
                y_reg <= y_reg - sx_step;
                z_reg <= z_reg + $signed({1'b0, atan_lut(step_reg)});
            end
            step_reg <= step_reg + STEP_BITS'(1);
        end
        if (ctl.scale)   px_reg <= PW'(x_reg) * PW'(CORDIC_K);
        if (ctl.scale_y) py_reg <= PW'(y_reg) * PW'(CORDIC_K);
    end

    // result register
    always_ff @(posedge aclk) begin
        if (ctl.emit) begin
            ro_vel_reg  <= is_vel_reg;
            ro_cal_reg  <= f_cal_reg;
            ro_vyaw_reg <= vyaw_reg;
            ro_fyaw_reg <= vyaw_reg - cal_base;
            if (is_vel_reg && ever_reg) begin
                ro_vx_reg   <= hvx_reg;
                ro_vy_reg   <= hvy_reg;
                ro_turn_reg <= hturn_reg;
            end else begin
                ro_vx_reg   <= '0;
                ro_vy_reg   <= '0;
                ro_turn_reg <= '0;
            end
        end
    end

    assign o_is_vel = ro_vel_reg;
    assign o_vx     = ro_vx_reg;
    assign o_vy     = ro_vy_reg;
    assign o_turn   = ro_turn_reg;
    assign o_vyaw   = ro_vyaw_reg;
    assign o_fyaw   = ro_fyaw_reg;
    assign o_cal    = ro_cal_reg;

    a_cal_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        f_cal_reg |=> f_cal_reg)
        else $error("calibration flag cleared");
    a_cal_needs_both: assert property (@(posedge aclk) disable iff (!aresetn)
        f_cal_reg |-> (f_base_reg && f_fb_reg))
        else $error("calibrated without base and feedback");
    a_hold_clears_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.hold |=> (su_reg == 16'd0 && ever_reg))
        else $error("hold did not restart timer");
endmodule
`default_nettype wire

// ===== design/yaw_compensated_velocity_rotator_top.sv =====
// Yaw compensated velocity rotator.
// Input stream s_axis: one event per transfer, selected by s_axis_tuser (cmd).
// Result stream m_axis: one transfer for a tick or publish event, none else.
// Configuration: cfg_we/cfg_idx/cfg_data write timeout, gain, zero band and
// initial spin speed; write only while the block is idle.
// Sequence: events without a rotation pass through decode and output before the
// next s_axis_tready; events that rotate a velocity pass through decode, the
// 16 iterations of the CORDIC unit, two gain multiplies, a hold and output.
// One event is worked on at a time.
// Results sit in an output register; the next event is taken while a result
// waits, but it holds in its output state until m_axis_tready takes the first.
// Reset (aresetn low, synchronous) clears all yaw state, flags and timers to
// their power-on values and loads the spin speed from the init register.
`default_nettype none
module yaw_compensated_velocity_rotator_top #(
    parameter int ANGLE_BITS = 16,
    parameter int VEL_BITS   = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // tdata: vel_x, vel_y, turn_rate, angle_in, synced (lowest first), zero fill
    input  wire logic [(2*VEL_BITS+16+ANGLE_BITS+1+7)/8*8-1:0] s_axis_tdata,
    // tuser: cmd
    input  wire logic [2:0]             s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // tdata: out_vx, out_vy, out_turn, virtual_yaw, frame_yaw, calibrated
    output logic [(2*VEL_BITS+16+2*ANGLE_BITS+1+7)/8*8-1:0] m_axis_tdata,
    // tuser: is_velocity
    output logic                        m_axis_tuser,
    input  wire logic                   cfg_we,
    input  wire logic [1:0]             cfg_idx,
    input  wire logic [15:0]            cfg_data
);
    import ycvr_pkg::*;

    localparam int IW = 2*VEL_BITS + 16 + ANGLE_BITS + 1;
    localparam int OW = 2*VEL_BITS + 16 + 2*ANGLE_BITS + 1;
    localparam int IB = (IW + 7) / 8 * 8;
    localparam int OB = (OW + 7) / 8 * 8;

    ycvr_ctl_t ctl;
    ycvr_sts_t sts;
    logic in_fire, out_fire;
    logic o_is_vel, o_cal;
    logic signed [VEL_BITS-1:0] o_vx, o_vy;
    logic signed [15:0] o_turn;
    logic [ANGLE_BITS-1:0] o_vyaw, o_fyaw;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    ycvr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .out_fire  (out_fire),
        .sts       (sts),
        .ctl       (ctl),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid)
    );

    ycvr_datapath #(.ANGLE_BITS(ANGLE_BITS), .VEL_BITS(VEL_BITS)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .sts       (sts),
        .in_cmd    (s_axis_tuser),
        .in_vx     (s_axis_tdata[VEL_BITS-1:0]),
        .in_vy     (s_axis_tdata[2*VEL_BITS-1:VEL_BITS]),
        .in_turn   (s_axis_tdata[2*VEL_BITS+15:2*VEL_BITS]),
        .in_angle  (s_axis_tdata[2*VEL_BITS+16+ANGLE_BITS-1:2*VEL_BITS+16]),
        .in_synced (s_axis_tdata[IW-1]),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data),
        .o_is_vel  (o_is_vel),
        .o_vx      (o_vx),
        .o_vy      (o_vy),
        .o_turn    (o_turn),
        .o_vyaw    (o_vyaw),
        .o_fyaw    (o_fyaw),
        .o_cal     (o_cal)
    );

    assign m_axis_tuser = o_is_vel;
    assign m_axis_tdata = OB'({o_cal, o_fyaw, o_vyaw, o_turn, o_vy, o_vx});

    logic unused_pad;
    assign unused_pad = ^s_axis_tdata[IB-1:IW];

endmodule
`default_nettype wire
